@@ sv/bat_pkg.sv @@
// ----------------------------------------------------------------------------
// bat_pkg - shared types and constants for the breakpoint address table
// Operation codes, cell commands and the match chain passed between cells.
// ----------------------------------------------------------------------------
package bat_pkg;

    localparam int ADDR_W   = 16;
    localparam int SLOTS_DEF = 16;

    // address value that marks an empty slot / no address
    localparam logic [ADDR_W-1:0] EMPTY_ADDR = 16'o177777;

    // request kinds
    typedef enum logic [2:0] {
        KIND_ADD      = 3'd0,
        KIND_REMOVE   = 3'd1,
        KIND_SET_TEMP = 3'd2,
        KIND_CLEAR    = 3'd3,
        KIND_CHECK    = 3'd4
    } kind_t;

    // command broadcast to every cell
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE,
        OP_APPEND,
        OP_CLEAR
    } cell_op_t;

    // prefix flags rippling from cell 0 upward
    typedef struct packed {
        logic gt_any;   // some lower cell holds a value greater than the key
        logic eq_any;   // some lower cell holds the key
    } cell_chain_t;

endpackage

@@ sv/bat_cell.sv @@
// ----------------------------------------------------------------------------
// bat_cell - one slot of the breakpoint table
// Holds one address, compares it with the key and shifts to/from neighbors.
// ----------------------------------------------------------------------------
module bat_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bat_pkg::cell_op_t         op,
    input  logic [bat_pkg::ADDR_W-1:0] key,
    input  logic                      append_here,
    input  logic [bat_pkg::ADDR_W-1:0] lower_val,
    input  logic [bat_pkg::ADDR_W-1:0] upper_val,
    input  bat_pkg::cell_chain_t      chain_in,
    output bat_pkg::cell_chain_t      chain_out,
    output logic [bat_pkg::ADDR_W-1:0] val
);
    import bat_pkg::*;

    logic [ADDR_W-1:0] val_reg;
    logic [ADDR_W-1:0] val_next;
    logic              gt;
    logic              eq;

    // compare against the key; the empty key never matches
    assign gt = (val_reg > key);
    assign eq = (key != EMPTY_ADDR) && (val_reg == key);

    assign chain_out.gt_any = chain_in.gt_any | gt;
    assign chain_out.eq_any = chain_in.eq_any | eq;
    assign val              = val_reg;

    // next slot value
    always_comb
    begin
        val_next = val_reg;
        case (op)
            OP_INSERT:
            begin
                if (chain_in.gt_any)
                    val_next = lower_val;
                else if (gt)
                    val_next = key;
            end
            OP_DELETE:
            begin
                if (chain_in.eq_any || eq)
                    val_next = upper_val;
            end
            OP_APPEND:
            begin
                if (append_here)
                    val_next = key;
            end
            OP_CLEAR:
                val_next = EMPTY_ADDR;
            default:
                val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            val_reg <= EMPTY_ADDR;
        else
            val_reg <= val_next;
    end

endmodule

@@ sv/breakpoint_address_table_core.sv @@
// ----------------------------------------------------------------------------
// breakpoint_address_table_core - breakpoint table built from a row of cells
// Add / remove / set-temporary / clear / check on a compact address table.
// ----------------------------------------------------------------------------
//  port group | dir | tdata                      | tuser
//  s_*        | in  | address[15:0]              | kind[2:0]
//  m_*        | out | accepted, hit, entry_count | -
//
//  Every request makes one pass over the cells, except set-temporary, which
//  makes two: the old temporary entry is removed through the cell row first,
//  and the new one is looked up and appended in the second pass.
//  The key match ripples combinationally through all SLOTS cells.
//  Reset empties all slots, clears the count and drops the temporary address.
//  A result waits in the output register; the next request is taken in the
//  same cycle that result is taken.
// ----------------------------------------------------------------------------
module breakpoint_address_table_core #(
    parameter  int SLOTS = bat_pkg::SLOTS_DEF,
    localparam int CNT_W = $clog2(SLOTS + 1),
    localparam int OUT_W = ((CNT_W + 2 + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [bat_pkg::ADDR_W-1:0] s_tdata,  // address
    input  logic [2:0]                 s_tuser,  // kind
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [OUT_W-1:0]           m_tdata   // accepted, hit, entry_count, zero pad
);
    import bat_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_TEMP
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] pend_reg, pend_next;
    logic [ADDR_W-1:0] temp_reg, temp_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              acc_reg, acc_next;
    logic              hit_reg, hit_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;

    logic              accept;
    kind_t             kind;
    logic [ADDR_W-1:0] key;
    cell_op_t          op;
    logic              key_none;
    logic              any_match;

    logic [ADDR_W-1:0] vals  [SLOTS];
    cell_chain_t       chain [SLOTS+1];

    assign kind     = kind_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_W - CNT_W - 2){1'b0}}, out_cnt_reg, hit_reg, acc_reg};

    // key select: pending address in the second pass, old temp in the first, else the request address
    always_comb
    begin
        if (state_reg == ST_TEMP)
            key = pend_reg;
        else if (kind == KIND_SET_TEMP)
            key = temp_reg;
        else
            key = s_tdata;
    end

    assign key_none  = (key == EMPTY_ADDR);
    assign any_match = chain[SLOTS].eq_any;

    // row of cells
    assign chain[0] = '0;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        logic [ADDR_W-1:0] lower_val;
        logic [ADDR_W-1:0] upper_val;

        if (g == 0)
        begin : g_low
            assign lower_val = EMPTY_ADDR;
        end
        else
        begin : g_low
            assign lower_val = vals[g-1];
        end

        if (g == SLOTS - 1)
        begin : g_up
            assign upper_val = EMPTY_ADDR;
        end
        else
        begin : g_up
            assign upper_val = vals[g+1];
        end

        bat_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .key         (key),
            .append_here (cnt_reg == CNT_W'(g)),
            .lower_val   (lower_val),
            .upper_val   (upper_val),
            .chain_in    (chain[g]),
            .chain_out   (chain[g+1]),
            .val         (vals[g])
        );
    end

    // control: decide the cell command, count and result
    always_comb
    begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        temp_next     = temp_reg;
        cnt_next      = cnt_reg;
        op            = OP_HOLD;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        acc_next      = acc_reg;
        hit_next      = hit_reg;
        out_cnt_next  = out_cnt_reg;

        if (state_reg == ST_TEMP)
        begin
            // second pass of set-temporary
            state_next = ST_IDLE;
            if (key_none)
                temp_next = EMPTY_ADDR;
            else if (any_match)
                temp_next = temp_reg;
            else if (cnt_reg >= CNT_W'(SLOTS))
                temp_next = EMPTY_ADDR;
            else
            begin
                op        = OP_APPEND;
                temp_next = pend_reg;
                cnt_next  = cnt_reg + 1'b1;
            end
            m_tvalid_next = 1'b1;
            acc_next      = 1'b0;
            hit_next      = 1'b0;
            out_cnt_next  = cnt_next;
        end
        else if (accept)
        begin
            m_tvalid_next = 1'b1;
            acc_next      = 1'b0;
            hit_next      = 1'b0;
            case (kind)
                KIND_ADD:
                begin
                    if (!key_none && cnt_reg < CNT_W'(SLOTS - 1) && !any_match)
                    begin
                        op       = OP_INSERT;
                        cnt_next = cnt_reg + 1'b1;
                        acc_next = 1'b1;
                    end
                end
                KIND_REMOVE:
                begin
                    if (cnt_reg != '0 && any_match)
                    begin
                        op       = OP_DELETE;
                        cnt_next = cnt_reg - 1'b1;
                        acc_next = 1'b1;
                    end
                end
                KIND_SET_TEMP:
                begin
                    // silent removal of the old temporary entry
                    if (any_match)
                    begin
                        op       = OP_DELETE;
                        cnt_next = cnt_reg - 1'b1;
                    end
                    pend_next     = s_tdata;
                    state_next    = ST_TEMP;
                    m_tvalid_next = 1'b0;
                end
                KIND_CLEAR:
                begin
                    op       = OP_CLEAR;
                    cnt_next = '0;
                end
                KIND_CHECK:
                    hit_next = any_match;
                default:
                    op = OP_HOLD;
            endcase
            out_cnt_next = cnt_next;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            temp_reg     <= EMPTY_ADDR;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            pend_reg     <= EMPTY_ADDR;
            acc_reg      <= 1'b0;
            hit_reg      <= 1'b0;
            out_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            temp_reg     <= temp_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            pend_reg     <= pend_next;
            acc_reg      <= acc_next;
            hit_reg      <= hit_next;
            out_cnt_reg  <= out_cnt_next;
        end
    end

endmodule
